// ===== src/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection package
// Shared widths, field offsets and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

	// Fraction bits of the signed fixed-point format.
	localparam int FRAC_BITS = 16;

	// Quotient magnitude width: 33-bit corner-origin difference scaled by 2^F.
	localparam int NUM_W = FRAC_BITS + 33;
	// Restoring division steps per pipeline stage, and stage count.
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

	// Input word: twelve 32-bit fields.
	localparam int IN_W = 384;

	// Output word layout.
	localparam int DIST_LSB = 0;
	localparam int PX_LSB = 31;
	localparam int PY_LSB = 63;
	localparam int PZ_LSB = 95;
	localparam int AXIS_LSB = 127;
	localparam int NEG_BIT = 129;
	localparam int OUT_FIELDS_W = 130;
	localparam int OUT_W = 136;

	// Normal axis codes.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_BAD = 2'd3;

	localparam logic [31:0] T_LOW = 32'h8000_0000;
	localparam logic [31:0] T_HIGH = 32'h7fff_ffff;

	typedef struct packed {
		logic [2:0][31:0] o;
		logic [2:0][31:0] d;
		logic [2:0][32:0] sum;   // lo + hi per axis
		logic [2:0] dzero;
		logic pmiss;
		logic [5:0] qneg;
	} pay_t;

	typedef struct packed {
		logic [5:0][31:0] dv;
		logic [5:0][31:0] rem;
		logic [5:0][NUM_W-1:0] nq;
	} div_t;

endpackage

`default_nettype wire

// ===== src/ray_box_slab_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection unit
// Fully pipelined ray versus axis-aligned box test in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (s_axis_*) takes one word per test: ray origin, ray
// direction, box lower and upper corners, all signed Q16.16.
// The master channel (m_axis_*) returns one word per test: the distance,
// the hit point and the face normal in tdata, and the hit flag in tuser.
// On a miss every output field is zero.
// The six slab quotients come out of a restoring divider pipeline that
// retires two quotient bits per stage, and that divider sets the depth.
// Throughput is one word per cycle: each stage loads whenever it is empty
// or its successor moves, so bubbles close up and a stalled output does not
// stop the front stages until they fill.
// When the receiver holds m_axis_tready low the output word stays put and
// nothing is lost or repeated. Reset clears all stage valid bits; the
// payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersection_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  wire logic [rbsi_pkg::IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// distance, point_x, point_y, point_z, normal_axis, normal_negative, pad
	output logic [rbsi_pkg::OUT_W-1:0] m_axis_tdata,
	// hit
	output logic [0:0] m_axis_tuser
);

	localparam int NW = rbsi_pkg::NUM_W;
	localparam int NS = rbsi_pkg::DIV_STAGES;
	localparam int F = rbsi_pkg::FRAC_BITS;

	// Stage handshake: a stage loads when it is empty or its successor loads.
	logic go_s1, go_s3, go_s4, go_s5, go_s6, go_s7, go_s8, go_s9, go_s10;
	logic [NS-1:0] go_s2;
	logic v_s1, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [NS-1:0] v_s2;

	assign go_s10 = !v_s10 || m_axis_tready;
	assign go_s9 = !v_s9 || go_s10;
	assign go_s8 = !v_s8 || go_s9;
	assign go_s7 = !v_s7 || go_s8;
	assign go_s6 = !v_s6 || go_s7;
	assign go_s5 = !v_s5 || go_s6;
	assign go_s4 = !v_s4 || go_s5;
	assign go_s3 = !v_s3 || go_s4;
	assign go_s1 = !v_s1 || go_s2[0];
	assign s_axis_tready = go_s1;

	// ------------------------------------------------------------------
	// Stage 1: unpack, form numerator and divisor magnitudes, quotient
	// signs and the parallel-slab checks.
	// ------------------------------------------------------------------
	rbsi_pkg::pay_t pay_in, pay_s1;
	rbsi_pkg::div_t div_in, div_s1;

	always_comb begin
		logic [31:0] o, d, lo, hi, cn;
		logic [32:0] diff, mag;
		logic [31:0] dmag;
		pay_in = '0;
		div_in = '0;
		for (int a = 0; a < 3; a++) begin
			o = s_axis_tdata[a*32 +: 32];
			d = s_axis_tdata[96 + a*32 +: 32];
			lo = s_axis_tdata[192 + a*32 +: 32];
			hi = s_axis_tdata[288 + a*32 +: 32];
			dmag = d[31] ? (32'd0 - d) : d;
			pay_in.o[a] = o;
			pay_in.d[a] = d;
			pay_in.sum[a] = 33'($signed({lo[31], lo}) + $signed({hi[31], hi}));
			pay_in.dzero[a] = (d == 32'd0);
			if ((d == 32'd0) && (($signed(o) < $signed(lo)) || ($signed(o) > $signed(hi))))
				pay_in.pmiss = 1'b1;
			for (int c = 0; c < 2; c++) begin
				cn = (c == 0) ? lo : hi;
				diff = 33'($signed({cn[31], cn}) - $signed({o[31], o}));
				mag = diff[32] ? (33'd0 - diff) : diff;
				pay_in.qneg[a*2 + c] = diff[32] ^ d[31];
				div_in.dv[a*2 + c] = dmag;
				div_in.rem[a*2 + c] = 32'd0;
				div_in.nq[a*2 + c] = {mag, {F{1'b0}}};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			pay_s1 <= pay_in;
			div_s1 <= div_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage group 2: restoring division, DIV_STEPS quotient bits a stage.
	// Quotient bits shift into the low end of nq as numerator bits leave.
	// ------------------------------------------------------------------
	rbsi_pkg::div_t div_s2 [NS];
	rbsi_pkg::pay_t pay_s2 [NS];

	for (genvar g = 0; g < NS; g++) begin : g_div
		rbsi_pkg::div_t din, dnx;
		rbsi_pkg::pay_t pin;
		logic vin;

		if (g == 0) begin : g_first
			assign din = div_s1;
			assign pin = pay_s1;
			assign vin = v_s1;
		end else begin : g_next
			assign din = div_s2[g-1];
			assign pin = pay_s2[g-1];
			assign vin = v_s2[g-1];
		end

		if (g == NS - 1) begin : g_last
			assign go_s2[g] = !v_s2[g] || go_s3;
		end else begin : g_mid
			assign go_s2[g] = !v_s2[g] || go_s2[g+1];
		end

		always_comb begin
			logic [32:0] rs;
			logic [31:0] r;
			logic [NW-1:0] n;
			dnx = din;
			for (int j = 0; j < 6; j++) begin
				r = din.rem[j];
				n = din.nq[j];
				for (int k = 0; k < rbsi_pkg::DIV_STEPS; k++) begin
					if ((g * rbsi_pkg::DIV_STEPS + k) < NW) begin
						rs = {r, n[NW-1]};
						n = {n[NW-2:0], 1'b0};
						if (rs >= {1'b0, din.dv[j]}) begin
							rs = rs - {1'b0, din.dv[j]};
							n[0] = 1'b1;
						end
						r = rs[31:0];
					end
				end
				dnx.rem[j] = r;
				dnx.nq[j] = n;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[g] <= 1'b0;
			end else if (go_s2[g]) begin
				v_s2[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (go_s2[g]) begin
				div_s2[g] <= dnx;
				pay_s2[g] <= pin;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: apply signs and saturate the quotients to 32 bits.
	// ------------------------------------------------------------------
	localparam logic [NW-1:0] QMAX_POS = NW'(64'h7fff_ffff);
	localparam logic [NW-1:0] QMAX_NEG = NW'(64'h8000_0000);

	logic [5:0][31:0] t_nx, t_s3;
	rbsi_pkg::pay_t pay_s3;

	always_comb begin
		logic [NW-1:0] q;
		for (int j = 0; j < 6; j++) begin
			q = div_s2[NS-1].nq[j];
			if (pay_s2[NS-1].qneg[j]) begin
				t_nx[j] = (q > QMAX_NEG) ? rbsi_pkg::T_LOW : (32'd0 - q[31:0]);
			end else begin
				t_nx[j] = (q > QMAX_POS) ? rbsi_pkg::T_HIGH : q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (go_s3) begin
			v_s3 <= v_s2[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (go_s3) begin
			t_s3 <= t_nx;
			pay_s3 <= pay_s2[NS-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: order each axis's crossings; parallel axes do not constrain.
	// ------------------------------------------------------------------
	logic [2:0][31:0] tmn_s4, tmx_s4;
	rbsi_pkg::pay_t pay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (go_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s4) begin
			pay_s4 <= pay_s3;
			for (int a = 0; a < 3; a++) begin
				if (pay_s3.dzero[a]) begin
					tmn_s4[a] <= rbsi_pkg::T_LOW;
					tmx_s4[a] <= rbsi_pkg::T_HIGH;
				end else if ($signed(t_s3[a*2]) < $signed(t_s3[a*2+1])) begin
					tmn_s4[a] <= t_s3[a*2];
					tmx_s4[a] <= t_s3[a*2+1];
				end else begin
					tmn_s4[a] <= t_s3[a*2+1];
					tmx_s4[a] <= t_s3[a*2];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: farthest entry and nearest exit.
	// ------------------------------------------------------------------
	logic [31:0] tnear_s5, tfar_s5;
	rbsi_pkg::pay_t pay_s5;
	logic [31:0] near01, far01;

	assign near01 = ($signed(tmn_s4[1]) > $signed(tmn_s4[0])) ? tmn_s4[1] : tmn_s4[0];
	assign far01 = ($signed(tmx_s4[1]) < $signed(tmx_s4[0])) ? tmx_s4[1] : tmx_s4[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (go_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s5) begin
			pay_s5 <= pay_s4;
			tnear_s5 <= ($signed(tmn_s4[2]) > $signed(near01)) ? tmn_s4[2] : near01;
			tfar_s5 <= ($signed(tmx_s4[2]) < $signed(far01)) ? tmx_s4[2] : far01;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: hit decision and distance.
	// ------------------------------------------------------------------
	logic hit_s6;
	logic [31:0] dist_s6;
	rbsi_pkg::pay_t pay_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (go_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s6) begin
			pay_s6 <= pay_s5;
			hit_s6 <= !pay_s5.pmiss && ($signed(tnear_s5) <= $signed(tfar_s5))
				&& ($signed(tfar_s5) > 0);
			dist_s6 <= ($signed(tnear_s5) > 0) ? tnear_s5 : tfar_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: direction times distance, one 32x32 product per axis.
	// ------------------------------------------------------------------
	logic hit_s7;
	logic [31:0] dist_s7;
	logic [2:0][63:0] prod_s7;
	rbsi_pkg::pay_t pay_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (go_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s7) begin
			pay_s7 <= pay_s6;
			hit_s7 <= hit_s6;
			dist_s7 <= dist_s6;
			for (int a = 0; a < 3; a++)
				prod_s7[a] <= 64'($signed(pay_s6.d[a]) * $signed(dist_s6));
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: hit point, floor shift plus origin, saturated.
	// ------------------------------------------------------------------
	logic hit_s8;
	logic [31:0] dist_s8;
	logic [2:0][31:0] p_s8;
	rbsi_pkg::pay_t pay_s8;
	logic [2:0][31:0] p_nx;

	always_comb begin
		logic [63:0] s;
		for (int a = 0; a < 3; a++) begin
			s = 64'($signed(prod_s7[a]) >>> F) + {{32{pay_s7.o[a][31]}}, pay_s7.o[a]};
			if ($signed(s) < $signed({{32{1'b1}}, rbsi_pkg::T_LOW}))
				p_nx[a] = rbsi_pkg::T_LOW;
			else if ($signed(s) > $signed({32'd0, rbsi_pkg::T_HIGH}))
				p_nx[a] = rbsi_pkg::T_HIGH;
			else
				p_nx[a] = s[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (go_s8) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s8) begin
			pay_s8 <= pay_s7;
			hit_s8 <= hit_s7;
			dist_s8 <= dist_s7;
			p_s8 <= p_nx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: twice the offset from the box center, and its magnitude.
	// ------------------------------------------------------------------
	logic hit_s9;
	logic [31:0] dist_s9;
	logic [2:0][31:0] p_s9;
	logic [2:0][33:0] off_s9, aoff_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (go_s9) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		logic [33:0] off;
		if (go_s9) begin
			hit_s9 <= hit_s8;
			dist_s9 <= dist_s8;
			p_s9 <= p_s8;
			for (int a = 0; a < 3; a++) begin
				off = 34'($signed({p_s8[a][31], p_s8[a], 1'b0})
					- $signed({pay_s8.sum[a][32], pay_s8.sum[a]}));
				off_s9[a] <= off;
				aoff_s9[a] <= off[33] ? (34'd0 - off) : off;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: normal axis choice and output register. Ties go to the
	// later axis: y beats x, z beats both. A miss clears every field.
	// ------------------------------------------------------------------
	logic [1:0] axis_nx;
	logic neg_nx;
	logic [rbsi_pkg::OUT_FIELDS_W-1:0] fields_s10;
	logic hit_s10;

	always_comb begin
		if ((aoff_s9[0] > aoff_s9[1]) && (aoff_s9[0] > aoff_s9[2]))
			axis_nx = rbsi_pkg::AXIS_X;
		else if (aoff_s9[1] > aoff_s9[2])
			axis_nx = rbsi_pkg::AXIS_Y;
		else
			axis_nx = rbsi_pkg::AXIS_Z;
		case (axis_nx)
			rbsi_pkg::AXIS_X: neg_nx = !($signed(off_s9[0]) > 0);
			rbsi_pkg::AXIS_Y: neg_nx = !($signed(off_s9[1]) > 0);
			default: neg_nx = !($signed(off_s9[2]) > 0);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (go_s10) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s10) begin
			hit_s10 <= hit_s9;
			if (hit_s9)
				fields_s10 <= {neg_nx, axis_nx, p_s9[2], p_s9[1], p_s9[0], dist_s9[30:0]};
			else
				fields_s10 <= '0;
		end
	end

	assign m_axis_tvalid = v_s10;
	assign m_axis_tdata = {{(rbsi_pkg::OUT_W - rbsi_pkg::OUT_FIELDS_W){1'b0}}, fields_s10};
	assign m_axis_tuser = hit_s10;

endmodule

`default_nettype wire

// ===== src/rbsi_checker.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`default_nettype none

module rbsi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [rbsi_pkg::OUT_W-1:0] m_axis_tdata,
	input wire logic [0:0] m_axis_tuser
);

	// A stalled word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// A miss carries all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("miss word not zero");

	// A hit lies ahead of the origin.
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0]
			|-> m_axis_tdata[rbsi_pkg::DIST_LSB +: 31] != 31'd0)
		else $error("hit with zero distance");

	// The normal axis is always a real axis.
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[rbsi_pkg::AXIS_LSB +: 2] != rbsi_pkg::AXIS_BAD)
		else $error("bad normal axis code");

endmodule

bind ray_box_slab_intersection_unit rbsi_checker u_rbsi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ray/box slab intersection unit testbench
// Drives ray/box words through the streaming input, predicts each outcome
// with a fixed-point slab test of its own, and checks every output word in
// order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import rbsi_pkg::*;

	localparam int LATENCY = 1 + DIV_STAGES + 8;
	localparam int N_RANDOM = 1250;

	// One ray/box test, in input word order.
	typedef struct {
		logic signed [31:0] o[3];
		logic signed [31:0] d[3];
		logic signed [31:0] lo[3];
		logic signed [31:0] hi[3];
	} ray_box_t;

	// One outcome of a test.
	typedef struct packed {
		logic hit;
		logic [30:0] distance;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [1:0] axis;
		logic neg;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	ray_box_slab_intersection_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	outcome_t pending_outcomes[$];
	int mismatches = 0;
	int words_checked = 0;
	int hits_seen = 0;
	bit stimulus_done = 0;
	bit quiet_phase = 0;      // no idling on either side near the end
	bit hold_sink = 0;        // long receiver hold-off request

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v < -64'sd2147483648) return -64'sd2147483648;
		if (v > 64'sd2147483647) return 64'sd2147483647;
		return v;
	endfunction

	function automatic logic signed [63:0] abs_wide(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Slab test. Division of signed vectors truncates toward zero, and the
	// arithmetic right shift rounds the hit point toward minus infinity.
	function automatic outcome_t slab_outcome(input ray_box_t r);
		outcome_t res;
		logic signed [63:0] tnear, tfar, t_hit, t1, t2, num;
		logic signed [63:0] p[3], off[3], a[3];
		logic signed [127:0] prod;
		bit parallel_miss;
		int ax;
		res = '0;
		tnear = -64'sd2147483648;
		tfar = 64'sd2147483647;
		parallel_miss = 0;
		for (int i = 0; i < 3; i++) begin
			if (r.d[i] == 0) begin
				if (r.o[i] < r.lo[i] || r.o[i] > r.hi[i]) parallel_miss = 1;
			end else begin
				num = (64'(r.lo[i]) - 64'(r.o[i])) <<< FRAC_BITS;
				t1 = clamp32(num / 64'(r.d[i]));
				num = (64'(r.hi[i]) - 64'(r.o[i])) <<< FRAC_BITS;
				t2 = clamp32(num / 64'(r.d[i]));
				if (t2 < t1) begin
					num = t1;
					t1 = t2;
					t2 = num;
				end
				if (t1 > tnear) tnear = t1;
				if (t2 < tfar) tfar = t2;
			end
		end
		if (parallel_miss || tnear > tfar || tfar <= 0) return res;
		t_hit = tnear > 0 ? tnear : tfar;
		for (int i = 0; i < 3; i++) begin
			prod = 128'(r.d[i]) * 128'(t_hit);
			p[i] = clamp32(64'(r.o[i]) + 64'(prod >>> FRAC_BITS));
			off[i] = 2 * p[i] - (64'(r.lo[i]) + 64'(r.hi[i]));
			a[i] = abs_wide(off[i]);
		end
		if (a[0] > a[1] && a[0] > a[2]) ax = 0;
		else if (a[1] > a[2]) ax = 1;
		else ax = 2;
		res.hit = 1;
		res.distance = t_hit[30:0];
		res.px = p[0][31:0];
		res.py = p[1][31:0];
		res.pz = p[2][31:0];
		res.axis = ax == 0 ? AXIS_X : (ax == 1 ? AXIS_Y : AXIS_Z);
		res.neg = off[ax] > 0 ? 1'b0 : 1'b1;
		return res;
	endfunction

	function automatic logic [IN_W-1:0] pack_ray_box(input ray_box_t r);
		logic [IN_W-1:0] w;
		for (int i = 0; i < 3; i++) begin
			w[32*i +: 32] = r.o[i];
			w[32*(3+i) +: 32] = r.d[i];
			w[32*(6+i) +: 32] = r.lo[i];
			w[32*(9+i) +: 32] = r.hi[i];
		end
		return w;
	endfunction

	function automatic logic [31:0] q(input int whole);
		return 32'(whole) <<< FRAC_BITS;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000 | ($urandom_range(0, 3));
			2: return 32'h7fff_ffff - $urandom_range(0, 3);
			3: return 0;
			default: return 32'($signed($urandom_range(0, 40)) - 20) <<< FRAC_BITS
				| $urandom_range(0, 65535);
		endcase
	endfunction

	// Mostly well-formed rays aimed near a small box, some pure noise.
	function automatic ray_box_t rand_ray_box();
		ray_box_t r;
		logic signed [31:0] c, h;
		bit noise;
		noise = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < 3; i++) begin
			if (noise) begin
				r.o[i] = rand_word();
				r.d[i] = rand_word();
				r.lo[i] = rand_word();
				r.hi[i] = rand_word();
			end else begin
				c = $signed($urandom_range(0, 2000)) - 1000;
				c = (c <<< FRAC_BITS) | $urandom_range(0, 65535);
				h = $urandom_range(1, 8 << FRAC_BITS);
				r.lo[i] = c - h;
				r.hi[i] = c + h;
				r.o[i] = c + (($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS)
					+ $urandom_range(0, 65535);
				case ($urandom_range(0, 7))
					0: r.d[i] = 0;
					1: r.d[i] = $urandom();
					2: r.d[i] = $signed($urandom_range(0, 8)) - 4;
					default: r.d[i] = ($signed($urandom_range(0, 4 << FRAC_BITS))
						- (2 << FRAC_BITS));
				endcase
				// Aim the ray back toward the box center now and then.
				if ($urandom_range(0, 1)) r.d[i] = (c - r.o[i]) >>> $urandom_range(0, 4);
				if ($urandom_range(0, 15) == 0) begin
					h = r.lo[i];
					r.lo[i] = r.hi[i];
					r.hi[i] = h;
				end
			end
		end
		return r;
	endfunction

	// Drive one word and hold it until accepted.
	task automatic send_word(input ray_box_t r);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= pack_ray_box(r);
		pending_outcomes.push_back(slab_outcome(r));
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_outcomes();
		s_axis_tvalid <= 0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// Directed table: row, and an expected outcome where it is obvious.
	typedef struct {
		ray_box_t r;
		bit known;
		outcome_t want;
	} table_row_t;

	table_row_t directed_rows[$];

	task automatic add_row(input ray_box_t r, input bit known, input outcome_t want);
		table_row_t row;
		row.r = r;
		row.known = known;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	task automatic build_table();
		ray_box_t r;
		outcome_t w;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 0; r.d[i] = 0; r.lo[i] = q(-1); r.hi[i] = q(1);
		end
		// All directions zero inside the box: hit at the largest distance,
		// point at the origin, which sits on the center, so every offset is
		// zero and the normal lands on z pointing negative.
		w = '0;
		w.hit = 1;
		w.distance = 31'h7fff_ffff;
		w.axis = AXIS_Z;
		w.neg = 1'b1;
		add_row(r, 1, w);
		// All zero fields: degenerate box holding the origin.
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 0; r.d[i] = 0; r.lo[i] = 0; r.hi[i] = 0;
		end
		add_row(r, 0, w);
		// Parallel axis with the origin outside: miss, all fields zero.
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 0; r.d[i] = 0; r.lo[i] = q(-1); r.hi[i] = q(1);
		end
		r.o[1] = q(5);
		add_row(r, 1, '0);
		// Parallel axis with swapped corners: miss.
		r.o[1] = 0; r.lo[1] = q(1); r.hi[1] = q(-1);
		add_row(r, 1, '0);
		// Ray along +x from outside, along -x, along y and z.
		r.lo[1] = q(-1); r.hi[1] = q(1);
		r.o[0] = q(-5); r.d[0] = q(1);
		add_row(r, 0, '0);
		r.o[0] = q(5); r.d[0] = q(-1);
		add_row(r, 0, '0);
		r.o[0] = 0; r.d[0] = 0; r.o[1] = q(-3); r.d[1] = q(2);
		add_row(r, 0, '0);
		r.o[1] = 0; r.d[1] = 0; r.o[2] = q(4); r.d[2] = q(-1);
		add_row(r, 0, '0);
		// Box behind the ray: miss.
		r.d[2] = q(1);
		add_row(r, 1, '0);
		// Origin inside, exit distance used; swapped non-parallel corners.
		r.o[2] = 0; r.d[0] = q(1); r.d[1] = q(1); r.d[2] = q(1);
		add_row(r, 0, '0);
		r.lo[0] = q(1); r.hi[0] = q(-1);
		add_row(r, 0, '0);
		// Corner hit: equal offsets go to the later axis, so z wins.
		r.lo[0] = q(-1); r.hi[0] = q(1);
		r.o[0] = q(-2); r.o[1] = q(-2); r.o[2] = q(-2);
		add_row(r, 0, '0);
		r.o[2] = q(-3);
		add_row(r, 0, '0);
		// Extreme fields: saturating quotients and points.
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 32'h8000_0000; r.d[i] = 1;
			r.lo[i] = 32'h7fff_fffe; r.hi[i] = 32'h7fff_ffff;
		end
		add_row(r, 0, '0);
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 32'h7fff_ffff; r.d[i] = 32'h8000_0000;
			r.lo[i] = 32'h8000_0000; r.hi[i] = 32'h7fff_ffff;
		end
		add_row(r, 0, '0);
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 32'hffff_ffff; r.d[i] = 32'h7fff_ffff;
			r.lo[i] = 32'h8000_0000; r.hi[i] = 32'h0000_0001;
		end
		add_row(r, 0, '0);
		for (int i = 0; i < 3; i++) begin
			r.o[i] = 32'h8000_0000; r.d[i] = 32'hffff_ffff;
			r.lo[i] = 32'h8000_0000; r.hi[i] = 32'h8000_0000;
		end
		add_row(r, 0, '0);
		// Entry through the lower y face, with tnear below tfar.
		for (int i = 0; i < 3; i++) begin
			r.o[i] = q(-2); r.d[i] = q(1); r.lo[i] = q(-1); r.hi[i] = q(1);
		end
		r.o[1] = q(-3);
		add_row(r, 0, '0);
		// Fractional direction with negative point rounding.
		r.o[0] = q(3) | 32'h0000_8001; r.d[0] = 32'hffff_0003;
		r.d[1] = 32'h0000_5555;
		add_row(r, 0, '0);
	endtask

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int stall;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 6);
				m_axis_tready <= 0;
				repeat (stall) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				@(posedge clk);
			end
		end
	end

	// Output checker: compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tuser[0];
			got.distance = m_axis_tdata[DIST_LSB +: 31];
			got.px = m_axis_tdata[PX_LSB +: 32];
			got.py = m_axis_tdata[PY_LSB +: 32];
			got.pz = m_axis_tdata[PZ_LSB +: 32];
			got.axis = m_axis_tdata[AXIS_LSB +: 2];
			got.neg = m_axis_tdata[NEG_BIT];
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output word %h", got);
			end else begin
				want = pending_outcomes.pop_front();
				words_checked++;
				if (got.hit) hits_seen++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch word %0d: expected hit=%b dist=%h p=%h,%h,%h ax=%0d neg=%b, got hit=%b dist=%h p=%h,%h,%h ax=%0d neg=%b",
							words_checked, want.hit, want.distance, want.px, want.py,
							want.pz, want.axis, want.neg, got.hit, got.distance,
							got.px, got.py, got.pz, got.axis, got.neg);
				end
			end
		end
	end

	// Sender and end of run.
	initial begin
		outcome_t w;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		build_table();
		foreach (directed_rows[k]) begin
			// Rows whose outcome is typed in must agree with the predictor.
			if (directed_rows[k].known) begin
				w = slab_outcome(directed_rows[k].r);
				if (w !== directed_rows[k].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: predictor %h, table %h", k, w,
							directed_rows[k].want);
				end
			end
			send_word(directed_rows[k].r);
		end
		// Pause until the pipe is empty.
		drain_outcomes();
		// Long receiver hold-off while words keep coming to fill the pipe.
		hold_sink = 1;
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM - 150) quiet_phase = 1;
			send_word(rand_ray_box());
		end
		s_axis_tvalid <= 0;
		stimulus_done = 1;
		fork
			begin
				while (pending_outcomes.size() != 0) @(posedge clk);
				repeat (LATENCY + 10) @(posedge clk);
			end
			begin
				repeat (200_000) @(posedge clk);
				$display("[FAIL] regression broken");
				$finish;
			end
		join_any
		$display("Covered %0d words (%0d hits) through directed edge cases and random rays,",
			words_checked, hits_seen);
		$display("with input gaps, output stalls and a long output hold-off.");
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/rbsi_pkg.sv
src/ray_box_slab_intersection_unit.sv
src/rbsi_checker.sv
tb/sv/tb_top.sv
